// ----- rtl/rqtd_pkg.sv -----
`timescale 1ns / 1ps

package rqtd_pkg;

  localparam int QUEUE_DEPTH = 8;
  localparam int TASK_COUNT  = 4;

  localparam int TASK_W   = 2;
  localparam int NUM_TASK = 4;
  localparam int TIME_W   = 32;
  localparam int PARAM_W  = 32;
  localparam int HALF_W   = 16;
  localparam int QC_W     = 4;
  localparam int CFG_IDX_W = 3;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // hold period 12000 = 375 << 5
  localparam int HOLD_UNIT  = 375;
  localparam int HOLD_LOW_W = 5;
  localparam logic [TIME_W-1:0] HOLD_PERIOD = TIME_W'(HOLD_UNIT << HOLD_LOW_W);
  localparam logic [TIME_W-1:0] HOLD_WINDOW = TIME_W'(2000);

  // reciprocal multiply for the remainder by HOLD_UNIT
  localparam int MOD_X_W     = TIME_W - HOLD_LOW_W;
  localparam int MODR_W      = 9;
  localparam int RECIP_SHIFT = MOD_X_W + MODR_W;
  localparam int RECIP_W     = 28;
  localparam int PROD_W      = MOD_X_W + RECIP_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;
  localparam logic [RECIP_W-1:0] RECIP_M =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(HOLD_UNIT) - 64'd1) / 64'(HOLD_UNIT));
  localparam int MOD_STEPS = 2;
  localparam int STEP_W    = 1;

  localparam logic [TASK_W-1:0] LAST_TASK = TASK_W'(TASK_COUNT - 1);

  localparam logic ACT_ENQ  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK0  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK1  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK2  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TASK3  = 3'd4;

  localparam logic [PARAM_W-1:0] TASK0_RESET = 32'd65536200;
  localparam logic [PARAM_W-1:0] TASK1_RESET = 32'd131072500;
  localparam logic [PARAM_W-1:0] TASK2_RESET = 32'd262145000;
  localparam logic [PARAM_W-1:0] TASK3_RESET = 32'd393217000;

  typedef enum logic [1:0] {
    FIN_OFF,
    FIN_ENQ,
    FIN_NONE,
    FIN_DISP
  } fin_kind_t;

  typedef struct packed {
    logic      take;
    logic      init;
    logic      scan_step;
    logic      mod_step;
    fin_kind_t fin_kind;
  } rqtd_cmd_t;

  typedef struct packed {
    logic is_enq;
    logic q_empty;
    logic busy;
    logic policy_edf;
    logic single_last;
    logic scan_last;
    logic mod_last;
    logic hold;
    logic out_free;
  } rqtd_stat_t;

  localparam rqtd_cmd_t CMD_NOP = '{
    take: 1'b0, init: 1'b0, scan_step: 1'b0, mod_step: 1'b0, fin_kind: FIN_OFF
  };

  localparam rqtd_cmd_t CMD_TAKE = '{
    take: 1'b1, init: 1'b0, scan_step: 1'b0, mod_step: 1'b0, fin_kind: FIN_OFF
  };

endpackage

// ----- rtl/rqtd_ctrl.sv -----
`timescale 1ns / 1ps

module rqtd_ctrl
  import rqtd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  rqtd_stat_t stat,
  output rqtd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_MOD,
    S_HOLD,
    S_FINISH
  } state_t;

  state_t    state_r, state_nxt;
  rqtd_cmd_t cmd_r, cmd_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = CMD_NOP;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt    = S_DECIDE;
          cmd_nxt.init = 1'b1;
        end else begin
          cmd_nxt.take = 1'b1;
        end
      end
      S_DECIDE: begin
        if (stat.is_enq) begin
          state_nxt        = S_FINISH;
          cmd_nxt.fin_kind = FIN_ENQ;
        end else if (stat.q_empty || stat.busy) begin
          state_nxt        = S_FINISH;
          cmd_nxt.fin_kind = FIN_NONE;
        end else if (!stat.policy_edf) begin
          state_nxt        = S_FINISH;
          cmd_nxt.fin_kind = FIN_DISP;
        end else if (stat.single_last) begin
          state_nxt        = S_MOD;
          cmd_nxt.mod_step = 1'b1;
        end else begin
          state_nxt         = S_SCAN;
          cmd_nxt.scan_step = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat.scan_last) begin
          state_nxt        = S_FINISH;
          cmd_nxt.fin_kind = FIN_DISP;
        end else begin
          cmd_nxt.scan_step = 1'b1;
        end
      end
      S_MOD: begin
        if (stat.mod_last) begin
          state_nxt = S_HOLD;
        end else begin
          cmd_nxt.mod_step = 1'b1;
        end
      end
      S_HOLD: begin
        state_nxt        = S_FINISH;
        cmd_nxt.fin_kind = stat.hold ? FIN_NONE : FIN_DISP;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          state_nxt    = S_IDLE;
          cmd_nxt.take = 1'b1;
        end else begin
          cmd_nxt = cmd_r;
        end
      end
      default: begin
        state_nxt    = S_IDLE;
        cmd_nxt.take = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_TAKE;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign cmd = cmd_r;

endmodule

// ----- rtl/rqtd_dp.sv -----
`timescale 1ns / 1ps

module rqtd_dp
  import rqtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  rqtd_cmd_t            cmd,
  output rqtd_stat_t           stat,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PARAM_W-1:0]   cfg_data,
  input  logic                 in_valid,
  input  logic                 in_action,
  input  logic [TASK_W-1:0]    in_task_number,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_dispatched,
  output logic [TASK_W-1:0]    out_dispatched_task,
  output logic [TIME_W-1:0]    out_finish_time,
  output logic                 out_status,
  output logic [QC_W-1:0]      out_queue_count
);

  // configuration
  logic               policy_r;
  logic [PARAM_W-1:0] params_r [NUM_TASK];

  // captured item
  logic              act_r;
  logic [TASK_W-1:0] task_r;
  logic [TIME_W-1:0] now_r;

  // queue and timing state
  logic [TASK_W-1:0] entries_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]  count_r;
  logic [TIME_W-1:0] busy_until_r;

  // deadline scan
  logic [IDX_W-1:0]  scan_idx_r;
  logic [IDX_W-1:0]  pick_r;
  logic              have_r;
  logic [HALF_W-1:0] best_d_r;
  logic [HALF_W-1:0] best_r_r;

  // modulo unit, reciprocal multiply then remainder
  logic [TIME_W-1:0] rem_r;
  logic [QUO_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;

  // result register
  logic              out_valid_r;
  logic              out_disp_r;
  logic [TASK_W-1:0] out_task_r;
  logic [TIME_W-1:0] out_finish_r;
  logic              out_status_r;
  logic [QC_W-1:0]   out_count_r;

  logic               load;
  logic               out_free;
  logic               fire;
  logic [TASK_W-1:0]  cur_task;
  logic [HALF_W-1:0]  cur_d;
  logic [HALF_W-1:0]  cur_r;
  logic               better;
  logic [MOD_X_W-1:0] mod_x;
  logic [QUO_W-1:0]   mod_quo;
  logic [MODR_W-1:0]  mod_rem;
  logic [TASK_W-1:0]  disp_task;
  logic [TIME_W-1:0]  disp_finish;
  logic               enq_full;
  logic               enq_valid;

  assign load     = in_valid && cmd.take;
  assign out_free = !out_valid_r || !out_stall;
  assign fire     = (cmd.fin_kind != FIN_OFF) && out_free;

  assign cur_task = entries_r[scan_idx_r];
  assign cur_d    = params_r[cur_task][PARAM_W-1:HALF_W];
  assign cur_r    = params_r[cur_task][HALF_W-1:0];
  assign better   = !have_r || (cur_d < best_d_r) ||
                    ((cur_d == best_d_r) && (cur_r < best_r_r));

  assign mod_x   = now_r[TIME_W-1:HOLD_LOW_W];
  assign mod_quo = QUO_W'((PROD_W'(mod_x) * PROD_W'(RECIP_M)) >> RECIP_SHIFT);
  assign mod_rem = MODR_W'(mod_x - MOD_X_W'(quo_r) * MOD_X_W'(HOLD_UNIT));

  assign disp_task   = entries_r[pick_r];
  assign disp_finish = now_r + TIME_W'(params_r[disp_task][HALF_W-1:0]);

  assign enq_valid = int'(task_r) < TASK_COUNT;
  assign enq_full  = int'(count_r) >= QUEUE_DEPTH;

  always_comb begin
    stat.is_enq      = (act_r == ACT_ENQ);
    stat.q_empty     = (count_r == '0);
    stat.busy        = (now_r < busy_until_r);
    stat.policy_edf  = policy_r;
    stat.single_last = (count_r == CNT_W'(1)) && (entries_r[0] == LAST_TASK);
    stat.scan_last   = (CNT_W'(scan_idx_r) == count_r - CNT_W'(1));
    stat.mod_last    = (step_r == '0);
    stat.hold        = (rem_r <= HOLD_WINDOW);
    stat.out_free    = out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= 1'b0;
      params_r[0] <= TASK0_RESET;
      params_r[1] <= TASK1_RESET;
      params_r[2] <= TASK2_RESET;
      params_r[3] <= TASK3_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY: policy_r    <= cfg_data[0];
        CFG_TASK0:  params_r[0] <= cfg_data;
        CFG_TASK1:  params_r[1] <= cfg_data;
        CFG_TASK2:  params_r[2] <= cfg_data;
        CFG_TASK3:  params_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r  <= in_action;
      task_r <= in_task_number;
      now_r  <= in_now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      scan_idx_r <= '0;
      pick_r     <= '0;
      have_r     <= 1'b0;
      step_r     <= STEP_W'(MOD_STEPS - 1);
    end else begin
      if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + IDX_W'(1);
        if (better) begin
          have_r   <= 1'b1;
          best_d_r <= cur_d;
          best_r_r <= cur_r;
          pick_r   <= scan_idx_r;
        end
      end
      if (cmd.mod_step) begin
        quo_r  <= mod_quo;
        rem_r  <= TIME_W'({mod_rem, now_r[HOLD_LOW_W-1:0]});
        step_r <= step_r - STEP_W'(1);
      end
    end
  end

  // queue contents, no reset
  always_ff @(posedge clk) begin
    if (fire && (cmd.fin_kind == FIN_ENQ) && enq_valid && !enq_full) begin
      entries_r[count_r[IDX_W-1:0]] <= task_r;
    end else if (fire && (cmd.fin_kind == FIN_DISP)) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= pick_r) begin
          entries_r[i] <= entries_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      busy_until_r <= '0;
    end else if (fire) begin
      case (cmd.fin_kind)
        FIN_ENQ: begin
          if (enq_valid && !enq_full) begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        FIN_DISP: begin
          count_r      <= count_r - CNT_W'(1);
          busy_until_r <= disp_finish;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      case (cmd.fin_kind)
        FIN_ENQ: begin
          out_disp_r   <= 1'b0;
          out_task_r   <= '0;
          out_finish_r <= busy_until_r;
          out_status_r <= enq_valid && enq_full;
          out_count_r  <= (enq_valid && !enq_full) ? QC_W'(count_r + CNT_W'(1))
                                                   : QC_W'(count_r);
        end
        FIN_DISP: begin
          out_disp_r   <= 1'b1;
          out_task_r   <= disp_task;
          out_finish_r <= disp_finish;
          out_status_r <= 1'b0;
          out_count_r  <= QC_W'(count_r - CNT_W'(1));
        end
        default: begin
          out_disp_r   <= 1'b0;
          out_task_r   <= '0;
          out_finish_r <= busy_until_r;
          out_status_r <= 1'b0;
          out_count_r  <= QC_W'(count_r);
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dispatched      = out_disp_r;
  assign out_dispatched_task = out_task_r;
  assign out_finish_time     = out_finish_r;
  assign out_status          = out_status_r;
  assign out_queue_count     = out_count_r;

endmodule

// ----- rtl/ready_queue_task_dispatcher.sv -----
`timescale 1ns / 1ps
// after transfer, S_DECIDE then S_FINISH load the result for enqueue, fifo release or none;
// deadline mode with N entries waiting adds S_SCAN (scan reads one entry per cycle);
// last task alone in deadline mode: S_MOD (mod 12000 by reciprocal, 2 steps), then S_HOLD.
// next item is taken the cycle after the result is loaded, so items are handled one at a time.
// synchronous active-low reset empties the queue, clears busy time and output valid,
// and restores the register defaults; queue contents are left as they are.

module ready_queue_task_dispatcher
  import rqtd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PARAM_W-1:0]   cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_action,
  input  logic [TASK_W-1:0]    in_task_number,
  input  logic [TIME_W-1:0]    in_now_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_dispatched,
  output logic [TASK_W-1:0]    out_dispatched_task,
  output logic [TIME_W-1:0]    out_finish_time,
  output logic                 out_status,
  output logic [QC_W-1:0]      out_queue_count
);

  rqtd_cmd_t  cmd;
  rqtd_stat_t stat;

  rqtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  rqtd_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_action           (in_action),
    .in_task_number      (in_task_number),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dispatched      (out_dispatched),
    .out_dispatched_task (out_dispatched_task),
    .out_finish_time     (out_finish_time),
    .out_status          (out_status),
    .out_queue_count     (out_queue_count)
  );

  assign in_stall = !cmd.take;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rqtd_pkg::*;

  localparam int MAX_GAP         = 14;
  localparam int LONG_HOLD       = 300;
  localparam int RAND_PHASES     = 10;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int DRAIN_CYCLES    = 30;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int PRINT_LIMIT     = 100;

  typedef struct packed {
    logic              disp;
    logic [TASK_W-1:0] disp_id;
    logic [TIME_W-1:0] finish;
    logic              status;
    logic [QC_W-1:0]   count;
  } dispatch_rec_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PARAM_W-1:0]   cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_action;
  logic [TASK_W-1:0]    in_task_number;
  logic [TIME_W-1:0]    in_now_ms;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_dispatched;
  logic [TASK_W-1:0]    out_dispatched_task;
  logic [TIME_W-1:0]    out_finish_time;
  logic                 out_status;
  logic [QC_W-1:0]      out_queue_count;

  logic [TASK_W-1:0]    ready_model[$];
  logic [TIME_W-1:0]    busy_model;
  logic                 edf_mode;
  logic [PARAM_W-1:0]   task_cfg[NUM_TASK];
  dispatch_rec_t        expected_dispatches[$];

  int  mismatch_count;
  int  cycle_count;
  bit  tx_idle_on;
  bit  rx_idle_on;
  bit  long_hold_req;

  ready_queue_task_dispatcher u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_task_number      (in_task_number),
    .in_now_ms           (in_now_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dispatched      (out_dispatched),
    .out_dispatched_task (out_dispatched_task),
    .out_finish_time     (out_finish_time),
    .out_status          (out_status),
    .out_queue_count     (out_queue_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic dispatch_rec_t predict_dispatch(input logic act,
                                                     input logic [TASK_W-1:0] tn,
                                                     input logic [TIME_W-1:0] now_ms);
    dispatch_rec_t     r;
    int                pick;
    int                i;
    logic              hold;
    logic [HALF_W-1:0] best_dl;
    logic [HALF_W-1:0] best_run;
    logic [HALF_W-1:0] dl;
    logic [HALF_W-1:0] run;
    r = '0;
    pick = 0;
    hold = 1'b0;
    best_dl = '0;
    best_run = '0;
    if (act == ACT_ENQ) begin
      if (tn < TASK_COUNT) begin
        if (ready_model.size() >= QUEUE_DEPTH) r.status = 1'b1;
        else ready_model.push_back(tn);
      end
    end else if (ready_model.size() > 0 && now_ms >= busy_model) begin
      if (edf_mode) begin
        hold = ready_model.size() == 1 && ready_model[0] == LAST_TASK &&
               (now_ms % HOLD_PERIOD) <= HOLD_WINDOW;
        for (i = 0; i < ready_model.size(); i++) begin
          dl  = task_cfg[ready_model[i]][PARAM_W-1:HALF_W];
          run = task_cfg[ready_model[i]][HALF_W-1:0];
          if (i == 0 || dl < best_dl || (dl == best_dl && run < best_run)) begin
            pick = i;
            best_dl = dl;
            best_run = run;
          end
        end
      end
      if (!hold) begin
        r.disp = 1'b1;
        r.disp_id = ready_model[pick];
        ready_model.delete(pick);
        busy_model = now_ms + TIME_W'(task_cfg[r.disp_id][HALF_W-1:0]);
      end
    end
    r.finish = busy_model;
    r.count = QC_W'(ready_model.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
  endtask

  always @(posedge clk) begin
    dispatch_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dispatches.size() == 0) begin
        report_mismatch("unexpected transfer", out_finish_time, '0);
      end else begin
        want = expected_dispatches.pop_front();
        if (out_dispatched !== want.disp)
          report_mismatch("dispatched", 32'(out_dispatched), 32'(want.disp));
        if (out_dispatched_task !== want.disp_id)
          report_mismatch("dispatched_task", 32'(out_dispatched_task), 32'(want.disp_id));
        if (out_finish_time !== want.finish)
          report_mismatch("finish_time", out_finish_time, want.finish);
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_queue_count !== want.count)
          report_mismatch("queue_count", 32'(out_queue_count), 32'(want.count));
      end
    end
  end

  // result side: random or long hold-off before each transfer
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LONG_HOLD;
      end else begin
        n = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  task automatic send_item(input logic act, input logic [TASK_W-1:0] tn,
                           input logic [TIME_W-1:0] now_ms);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_action <= act;
    in_task_number <= tn;
    in_now_ms <= now_ms;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_dispatches.push_back(predict_dispatch(act, tn, now_ms));
  endtask

  task automatic wait_idle;
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_dispatches.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [PARAM_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POLICY: edf_mode = val[0];
      CFG_TASK0, CFG_TASK1, CFG_TASK2, CFG_TASK3: task_cfg[idx - CFG_TASK0] = val;
      default: ;
    endcase
  endtask

  function automatic logic [PARAM_W-1:0] pick_params(input int phase);
    logic [HALF_W-1:0] dl;
    logic [HALF_W-1:0] run;
    if (phase == 0) return '0;
    if (phase == 1) return '1;
    // narrow deadline range so ties are common
    dl  = ($urandom_range(0, 3) != 0) ? HALF_W'($urandom_range(0, 4)) : HALF_W'($urandom);
    run = ($urandom_range(0, 3) != 0) ? HALF_W'($urandom_range(0, 1200)) : HALF_W'($urandom);
    return {dl, run};
  endfunction

  task automatic test_fifo_defaults;
    int k;
    for (k = 0; k < NUM_TASK; k++) send_item(ACT_ENQ, TASK_W'(k), $urandom);
    send_item(ACT_TICK, '0, '0);
    send_item(ACT_TICK, '1, 32'd199);
    send_item(ACT_TICK, '0, 32'd200);
    send_item(ACT_TICK, '1, 32'hFFFF_FFFF);
  endtask

  task automatic test_last_task_hold;
    wait_idle();
    cfg_write(CFG_POLICY, 32'd1);
    send_item(ACT_TICK, '0, HOLD_PERIOD * 2);
    send_item(ACT_TICK, '0, HOLD_PERIOD + HOLD_WINDOW);
    send_item(ACT_TICK, '0, HOLD_PERIOD * 3 + HOLD_WINDOW + 1);
    send_item(ACT_TICK, '0, HOLD_PERIOD * 4);
  endtask

  task automatic test_unmapped_index;
    int k;
    wait_idle();
    for (k = int'(CFG_TASK3) + 1; k < 2 ** CFG_IDX_W; k++) cfg_write(CFG_IDX_W'(k), '1);
    send_item(ACT_ENQ, '0, '0);
    send_item(ACT_TICK, '0, HOLD_PERIOD * 5);
  endtask

  task automatic test_deadline_order;
    wait_idle();
    cfg_write(CFG_TASK0, {16'd5, 16'd9});
    cfg_write(CFG_TASK1, {16'd5, 16'd3});
    cfg_write(CFG_TASK2, {16'd5, 16'd3});
    cfg_write(CFG_TASK3, '1);
    send_item(ACT_ENQ, TASK_W'(3), '0);
    send_item(ACT_ENQ, TASK_W'(0), '0);
    send_item(ACT_ENQ, TASK_W'(2), '0);
    send_item(ACT_ENQ, TASK_W'(1), '0);
    send_item(ACT_TICK, '0, 32'd100000);
    send_item(ACT_TICK, '0, 32'd100003);
    send_item(ACT_TICK, '0, 32'd100006);
    send_item(ACT_TICK, '0, HOLD_PERIOD * 10 + 1);
    send_item(ACT_TICK, '0, 32'hFFFF_FFFF);
  endtask

  task automatic test_queue_full;
    int k;
    for (k = 0; k <= QUEUE_DEPTH; k++) send_item(ACT_ENQ, TASK_W'(k), $urandom);
  endtask

  task automatic test_random_phases;
    int phase;
    int n;
    int k;
    int enq_pct;
    logic [TIME_W-1:0] clock_ms;
    clock_ms = $urandom_range(0, 100000);
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      cfg_write(CFG_POLICY, ($urandom & ~32'd1) | PARAM_W'(phase % 2));
      for (k = 0; k < NUM_TASK; k++) cfg_write(CFG_IDX_W'(CFG_TASK0 + k), pick_params(phase));
      enq_pct = $urandom_range(35, 65);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 39) == 0) begin
          tx_idle_on = $urandom_range(0, 3) != 0;
          rx_idle_on = $urandom_range(0, 3) != 0;
        end
        if ($urandom_range(0, 29) == 0) begin
          for (k = 0; k <= QUEUE_DEPTH; k++)
            send_item(ACT_ENQ, TASK_W'($urandom_range(0, NUM_TASK - 1)), $urandom);
          n += QUEUE_DEPTH + 1;
        end else if ($urandom_range(0, 99) < enq_pct) begin
          send_item(ACT_ENQ, TASK_W'($urandom_range(0, NUM_TASK - 1)), $urandom);
          n++;
        end else begin
          case ($urandom_range(0, 19))
            0: clock_ms = $urandom;
            1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
            2: clock_ms = (clock_ms / HOLD_PERIOD + 1) * HOLD_PERIOD + $urandom_range(0, 2500);
            default: clock_ms = clock_ms + $urandom_range(0, 1500);
          endcase
          send_item(ACT_TICK, TASK_W'($urandom), clock_ms);
          n++;
        end
      end
    end
  endtask

  task automatic test_output_backpressure;
    int k;
    logic [TIME_W-1:0] clock_ms;
    wait_idle();
    tx_idle_on = 1'b0;
    long_hold_req = 1'b1;
    clock_ms = busy_model;
    for (k = 0; k < 24; k++) begin
      if (k % 2 == 0) begin
        send_item(ACT_ENQ, TASK_W'($urandom_range(0, NUM_TASK - 1)), $urandom);
      end else begin
        clock_ms = clock_ms + $urandom_range(0, 1500);
        send_item(ACT_TICK, TASK_W'($urandom), clock_ms);
      end
    end
    tx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_ENQ;
    in_task_number = '0;
    in_now_ms = '0;
    mismatch_count = 0;
    cycle_count = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    long_hold_req = 1'b0;
    ready_model.delete();
    busy_model = '0;
    edf_mode = 1'b0;
    task_cfg[0] = TASK0_RESET;
    task_cfg[1] = TASK1_RESET;
    task_cfg[2] = TASK2_RESET;
    task_cfg[3] = TASK3_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fifo_defaults();
    test_last_task_hold();
    test_unmapped_index();
    test_deadline_order();
    test_queue_full();
    test_random_phases();
    test_output_backpressure();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
